[hw/rtl/mrc_pkg.sv]
`default_nettype none
package mrc_pkg;

	// table capacity and field widths
	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int FRAME_W     = 52;
	localparam int TYPE_W      = 4;

	// usable descriptor type codes
	localparam logic [TYPE_W-1:0] MT_LOADER_CODE  = 4'd1;
	localparam logic [TYPE_W-1:0] MT_LOADER_DATA  = 4'd2;
	localparam logic [TYPE_W-1:0] MT_BOOT_CODE    = 4'd3;
	localparam logic [TYPE_W-1:0] MT_BOOT_DATA    = 4'd4;
	localparam logic [TYPE_W-1:0] MT_CONVENTIONAL = 4'd7;

	// one table entry as stored in the region memory
	typedef struct packed {
		logic [FRAME_W-1:0] start;
		logic [FRAME_W-1:0] pages;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// operations of the shared add/compare unit
	typedef enum logic [1:0] {
		ALU_IDLE = 2'd0,
		ALU_END  = 2'd1,
		ALU_CAND = 2'd2,
		ALU_JOIN = 2'd3
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic    load_cur;
		logic    load_cand;
	} alu_ctl_t;

	// sequencer states
	typedef enum logic [10:0] {
		ST_LOAD   = 11'b000_0000_0001,
		ST_S_RD   = 11'b000_0000_0010,
		ST_S_GET  = 11'b000_0000_0100,
		ST_S_END  = 11'b000_0000_1000,
		ST_C_RD   = 11'b000_0001_0000,
		ST_C_GET  = 11'b000_0010_0000,
		ST_C_CMP  = 11'b000_0100_0000,
		ST_JOIN   = 11'b000_1000_0000,
		ST_O_RD   = 11'b001_0000_0000,
		ST_O_GET  = 11'b010_0000_0000,
		ST_O_WAIT = 11'b100_0000_0000
	} state_t;

	function automatic logic type_usable(input logic [TYPE_W-1:0] t);
		logic usable;
		case (t) inside
			MT_LOADER_CODE, MT_LOADER_DATA, MT_BOOT_CODE, MT_BOOT_DATA,
			MT_CONVENTIONAL: usable = 1'b1;
			default:         usable = 1'b0;
		endcase
		return usable;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/mrc_desc_if.sv]
`default_nettype none
interface mrc_desc_if;
	logic                        valid;
	logic                        ready;
	logic [mrc_pkg::TYPE_W-1:0]  mem_type;
	logic [mrc_pkg::FRAME_W-1:0] start_frame;
	logic [mrc_pkg::FRAME_W-1:0] page_count;
	logic                        last_entry;

	modport source (
		output valid, mem_type, start_frame, page_count, last_entry,
		input  ready
	);
	modport sink (
		input  valid, mem_type, start_frame, page_count, last_entry,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/mrc_region_if.sv]
`default_nettype none
interface mrc_region_if;
	logic                        valid;
	logic                        ready;
	logic [mrc_pkg::FRAME_W-1:0] region_start;
	logic [mrc_pkg::FRAME_W-1:0] region_pages;
	logic                        last_region;
	logic                        map_empty;
	logic                        overflow;

	modport source (
		output valid, region_start, region_pages, last_region, map_empty, overflow,
		input  ready
	);
	modport sink (
		input  valid, region_start, region_pages, last_region, map_empty, overflow,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/mrc_ram.sv]
`default_nettype none
module mrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/mrc_alu.sv]
`default_nettype none
module mrc_alu (
	input  wire logic                        clk,
	input  wire mrc_pkg::alu_ctl_t           ctl,
	input  wire mrc_pkg::entry_t             rd_entry,
	output logic                             match,
	output mrc_pkg::entry_t                  wr_entry
);

	logic [mrc_pkg::FRAME_W-1:0] cur_st_q;
	logic [mrc_pkg::FRAME_W-1:0] cur_pg_q;
	logic [mrc_pkg::FRAME_W-1:0] cur_en_q;
	logic [mrc_pkg::FRAME_W-1:0] cand_st_q;
	logic [mrc_pkg::FRAME_W-1:0] cand_pg_q;
	logic                        join_low_q;
	logic [mrc_pkg::FRAME_W-1:0] op_a;
	logic [mrc_pkg::FRAME_W-1:0] op_b;
	logic [mrc_pkg::FRAME_W-1:0] sum;

	// operand select for the shared adder
	always_comb begin
		unique case (ctl.op)
			mrc_pkg::ALU_END: begin
				op_a = cur_st_q;
				op_b = cur_pg_q;
			end
			mrc_pkg::ALU_CAND: begin
				op_a = cand_st_q;
				op_b = cand_pg_q;
			end
			mrc_pkg::ALU_JOIN: begin
				op_a = cur_pg_q;
				op_b = cand_pg_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// sum wraps at the frame width
	assign sum = op_a + op_b;

	// candidate starts at our end, or ends at our start
	assign match = (ctl.op == mrc_pkg::ALU_CAND) &&
		((cand_st_q == cur_en_q) || (sum == cur_st_q));

	// merged entry, written back in the join cycle
	assign wr_entry.start = join_low_q ? cand_st_q : cur_st_q;
	assign wr_entry.pages = sum;

	// working registers of the current and candidate regions
	always_ff @(posedge clk) begin
		if (ctl.load_cur) begin
			cur_st_q <= rd_entry.start;
			cur_pg_q <= rd_entry.pages;
		end
		if (ctl.load_cand) begin
			cand_st_q <= rd_entry.start;
			cand_pg_q <= rd_entry.pages;
		end
		if (ctl.op == mrc_pkg::ALU_END) begin
			cur_en_q <= sum;
		end
		if (ctl.op == mrc_pkg::ALU_CAND) begin
			join_low_q <= (cand_st_q != cur_en_q);
		end
		if (ctl.op == mrc_pkg::ALU_JOIN) begin
			cur_st_q <= wr_entry.start;
			cur_pg_q <= sum;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/memory_region_coalescer_core.sv]
`default_nettype none
// channel  dir  handshake      payload
// desc     in   valid/ready    mem_type, start_frame, page_count, last_entry
// region   out  valid/ready    region_start, region_pages, last_region, map_empty, overflow
//
// loading takes one descriptor per cycle; the walk starts after the descriptor marked last
// walk: dead slots are skipped; each live slot is read and its end summed, then later live
// slots are read and compared; a join writes back and rescans; one adder does it all
// output: dead slots are skipped; each region, or one item for an empty map, waits for region.ready
// reset clears control state and live bits only; table memory needs no clearing pass
// desc.ready is high only while loading; a region item holds until taken
module memory_region_coalescer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mrc_desc_if.sink        desc,
	mrc_region_if.source    region
);

	localparam logic [mrc_pkg::CNT_W-1:0] CAP = mrc_pkg::CNT_W'(mrc_pkg::MAX_ENTRIES);

	mrc_pkg::state_t                   state_q;
	logic [mrc_pkg::CNT_W-1:0]         count_q;
	logic [mrc_pkg::CNT_W-1:0]         s_q;
	logic [mrc_pkg::CNT_W-1:0]         c_q;
	logic                              dropped_q;
	logic [mrc_pkg::MAX_ENTRIES-1:0]   live_q;
	logic [mrc_pkg::FRAME_W-1:0]       out_start_q;
	logic [mrc_pkg::FRAME_W-1:0]       out_pages_q;
	logic                              out_last_q;
	logic                              out_empty_q;

	logic                              acc;
	logic                              room;
	logic                              live_above;
	logic                              ram_we;
	logic [mrc_pkg::IDX_W-1:0]         ram_waddr;
	mrc_pkg::entry_t                   ram_wdata;
	logic [mrc_pkg::IDX_W-1:0]         ram_raddr;
	mrc_pkg::entry_t                   ram_rdata;
	mrc_pkg::alu_ctl_t                 alu_ctl;
	logic                              alu_match;
	mrc_pkg::entry_t                   alu_wr;

	assign desc.ready = (state_q == mrc_pkg::ST_LOAD);
	assign acc        = desc.valid && desc.ready;
	assign room       = (count_q < CAP);

	// any live slot after the one being emitted
	always_comb begin
		live_above = 1'b0;
		for (int i = 0; i < mrc_pkg::MAX_ENTRIES; i++) begin
			if (live_q[i] && (mrc_pkg::CNT_W'(i) > s_q)) begin
				live_above = 1'b1;
			end
		end
	end

	// table memory port control
	always_comb begin
		ram_we          = 1'b0;
		ram_waddr       = count_q[mrc_pkg::IDX_W-1:0];
		ram_wdata.start = desc.start_frame;
		ram_wdata.pages = desc.page_count;
		ram_raddr       = s_q[mrc_pkg::IDX_W-1:0];
		if (state_q == mrc_pkg::ST_LOAD) begin
			ram_we = acc && room;
		end
		if (state_q == mrc_pkg::ST_JOIN) begin
			ram_we    = 1'b1;
			ram_waddr = s_q[mrc_pkg::IDX_W-1:0];
			ram_wdata = alu_wr;
		end
		if (state_q == mrc_pkg::ST_C_RD) begin
			ram_raddr = c_q[mrc_pkg::IDX_W-1:0];
		end
	end

	// shared unit control
	always_comb begin
		alu_ctl.load_cur  = (state_q == mrc_pkg::ST_S_GET);
		alu_ctl.load_cand = (state_q == mrc_pkg::ST_C_GET);
		unique case (state_q)
			mrc_pkg::ST_S_END: alu_ctl.op = mrc_pkg::ALU_END;
			mrc_pkg::ST_C_CMP: alu_ctl.op = mrc_pkg::ALU_CAND;
			mrc_pkg::ST_JOIN:  alu_ctl.op = mrc_pkg::ALU_JOIN;
			default:           alu_ctl.op = mrc_pkg::ALU_IDLE;
		endcase
	end

	mrc_ram #(
		.WIDTH(mrc_pkg::ENTRY_W),
		.DEPTH(mrc_pkg::MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mrc_alu u_alu (
		.clk      (clk),
		.ctl      (alu_ctl),
		.rd_entry (ram_rdata),
		.match    (alu_match),
		.wr_entry (alu_wr)
	);

	// sequencer: load, walk and join, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mrc_pkg::ST_LOAD;
			count_q   <= '0;
			s_q       <= '0;
			c_q       <= '0;
			dropped_q <= 1'b0;
			live_q    <= '0;
		end else begin
			unique case (state_q)
				mrc_pkg::ST_LOAD: begin
					if (acc) begin
						if (room) begin
							live_q[count_q[mrc_pkg::IDX_W-1:0]] <=
								mrc_pkg::type_usable(desc.mem_type);
							count_q <= count_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (desc.last_entry) begin
							s_q     <= '0;
							state_q <= mrc_pkg::ST_S_RD;
						end
					end
				end
				mrc_pkg::ST_S_RD: begin
					if (s_q >= count_q) begin
						s_q     <= '0;
						state_q <= mrc_pkg::ST_O_RD;
					end else if (!live_q[s_q[mrc_pkg::IDX_W-1:0]]) begin
						s_q <= s_q + 1'b1;
					end else begin
						state_q <= mrc_pkg::ST_S_GET;
					end
				end
				mrc_pkg::ST_S_GET: begin
					state_q <= mrc_pkg::ST_S_END;
				end
				mrc_pkg::ST_S_END: begin
					c_q     <= s_q + 1'b1;
					state_q <= mrc_pkg::ST_C_RD;
				end
				mrc_pkg::ST_C_RD: begin
					if (c_q >= count_q) begin
						s_q     <= s_q + 1'b1;
						state_q <= mrc_pkg::ST_S_RD;
					end else if (!live_q[c_q[mrc_pkg::IDX_W-1:0]]) begin
						c_q <= c_q + 1'b1;
					end else begin
						state_q <= mrc_pkg::ST_C_GET;
					end
				end
				mrc_pkg::ST_C_GET: begin
					state_q <= mrc_pkg::ST_C_CMP;
				end
				mrc_pkg::ST_C_CMP: begin
					if (alu_match) begin
						state_q <= mrc_pkg::ST_JOIN;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= mrc_pkg::ST_C_RD;
					end
				end
				mrc_pkg::ST_JOIN: begin
					// absorbed slot dies, then the candidate scan restarts after the current slot
					live_q[c_q[mrc_pkg::IDX_W-1:0]] <= 1'b0;
					state_q <= mrc_pkg::ST_S_END;
				end
				mrc_pkg::ST_O_RD: begin
					if (s_q >= count_q) begin
						state_q <= mrc_pkg::ST_O_WAIT;
					end else if (!live_q[s_q[mrc_pkg::IDX_W-1:0]]) begin
						s_q <= s_q + 1'b1;
					end else begin
						state_q <= mrc_pkg::ST_O_GET;
					end
				end
				mrc_pkg::ST_O_GET: begin
					state_q <= mrc_pkg::ST_O_WAIT;
				end
				mrc_pkg::ST_O_WAIT: begin
					if (region.ready) begin
						if (out_last_q) begin
							count_q   <= '0;
							s_q       <= '0;
							dropped_q <= 1'b0;
							live_q    <= '0;
							state_q   <= mrc_pkg::ST_LOAD;
						end else begin
							s_q     <= s_q + 1'b1;
							state_q <= mrc_pkg::ST_O_RD;
						end
					end
				end
				default: begin
					state_q <= mrc_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if ((state_q == mrc_pkg::ST_O_RD) && (s_q >= count_q)) begin
			out_start_q <= '0;
			out_pages_q <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
		end
		if (state_q == mrc_pkg::ST_O_GET) begin
			out_start_q <= ram_rdata.start;
			out_pages_q <= ram_rdata.pages;
			out_last_q  <= !live_above;
			out_empty_q <= 1'b0;
		end
	end

	assign region.valid        = (state_q == mrc_pkg::ST_O_WAIT);
	assign region.region_start = out_start_q;
	assign region.region_pages = out_pages_q;
	assign region.last_region  = out_last_q;
	assign region.map_empty    = out_empty_q;
	assign region.overflow     = dropped_q;

endmodule
`default_nettype wire

[tb/tb.sv]
module tb;

	// no item moved on either channel for this many cycles means a hang
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int TAIL_CYCLES    = 100;
	localparam int RANDOM_ITEMS   = 144;

	localparam int MAX_ENTRIES = mrc_pkg::MAX_ENTRIES;
	localparam int FRAME_W     = mrc_pkg::FRAME_W;
	localparam int TYPE_W      = mrc_pkg::TYPE_W;

	// unusable type codes used by name in the directed maps
	localparam logic [TYPE_W-1:0] MT_RESERVED     = 4'd0;
	localparam logic [TYPE_W-1:0] MT_RUNTIME_CODE = 4'd5;
	localparam logic [TYPE_W-1:0] MT_UNUSABLE     = 4'd8;

	localparam logic [FRAME_W-1:0] FRAME_ONES = '1;

	typedef struct packed {
		logic [FRAME_W-1:0] start;
		logic [FRAME_W-1:0] pages;
		logic               last_region;
		logic               map_empty;
		logic               overflow;
	} region_exp_t;

	// predicts the coalesced regions of each map and checks them in order
	class region_scoreboard;
		logic [FRAME_W-1:0] tbl_start [MAX_ENTRIES];
		logic [FRAME_W-1:0] tbl_pages [MAX_ENTRIES];
		bit                 live      [MAX_ENTRIES];
		int                 fill;
		bit                 dropped;
		region_exp_t        pending [$];
		int errors;
		int maps;
		int descs;
		int regions;
		int joins;
		int overflow_maps;
		int empty_maps;

		function new();
			clear_map();
			errors        = 0;
			maps          = 0;
			descs         = 0;
			regions       = 0;
			joins         = 0;
			overflow_maps = 0;
			empty_maps    = 0;
		endfunction

		function void clear_map();
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				live[i] = 1'b0;
			end
			fill    = 0;
			dropped = 1'b0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		function bit usable(logic [TYPE_W-1:0] t);
			return t == mrc_pkg::MT_LOADER_CODE || t == mrc_pkg::MT_LOADER_DATA ||
				t == mrc_pkg::MT_BOOT_CODE || t == mrc_pkg::MT_BOOT_DATA ||
				t == mrc_pkg::MT_CONVENTIONAL;
		endfunction

		// merge the first later live slot that touches slot s at either end
		function bit absorb_one(int s, int n);
			logic [FRAME_W-1:0] s_beg, s_end, c_beg, c_end;
			s_beg = tbl_start[s];
			s_end = s_beg + tbl_pages[s];
			for (int c = s + 1; c < n; c++) begin
				if (live[c]) begin
					c_beg = tbl_start[c];
					c_end = c_beg + tbl_pages[c];
					if (c_beg == s_end || c_end == s_beg) begin
						if (c_beg != s_end) begin
							tbl_start[s] = c_beg;
						end
						tbl_pages[s] = tbl_pages[s] + tbl_pages[c];
						live[c] = 1'b0;
						joins++;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		// walk the table, then queue the surviving regions in slot order
		function void coalesce_map();
			int          survivors;
			int          k;
			region_exp_t r;
			for (int s = 0; s < fill; s++) begin
				if (live[s]) begin
					while (absorb_one(s, fill)) begin
					end
				end
			end
			survivors = 0;
			for (int s = 0; s < fill; s++) begin
				if (live[s]) survivors++;
			end
			k = 0;
			for (int s = 0; s < fill; s++) begin
				if (live[s]) begin
					r.start       = tbl_start[s];
					r.pages       = tbl_pages[s];
					r.last_region = (k == survivors - 1);
					r.map_empty   = 1'b0;
					r.overflow    = dropped;
					pending.push_back(r);
					k++;
				end
			end
			if (survivors == 0) begin
				r             = '0;
				r.last_region = 1'b1;
				r.map_empty   = 1'b1;
				r.overflow    = dropped;
				pending.push_back(r);
				empty_maps++;
			end
			maps++;
			if (dropped) overflow_maps++;
			clear_map();
		endfunction

		function void note_desc(logic [TYPE_W-1:0] t, logic [FRAME_W-1:0] st,
				logic [FRAME_W-1:0] pg, logic last);
			descs++;
			if (fill < MAX_ENTRIES) begin
				tbl_start[fill] = st;
				tbl_pages[fill] = pg;
				live[fill]      = usable(t);
				fill++;
			end else begin
				dropped = 1'b1;
			end
			if (last) coalesce_map();
		endfunction

		function void compare_field(string name, logic [FRAME_W-1:0] want,
				logic [FRAME_W-1:0] got);
			if (want !== got) begin
				report($sformatf("region %0d %s expected %h got %h", regions, name, want, got));
			end
		endfunction

		function void check_region(logic [FRAME_W-1:0] st, logic [FRAME_W-1:0] pg,
				logic lr, logic me, logic ov);
			region_exp_t e;
			regions++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected region item start=%h pages=%h", st, pg));
				return;
			end
			e = pending.pop_front();
			compare_field("region_start", e.start, st);
			compare_field("region_pages", e.pages, pg);
			compare_field("last_region", e.last_region, lr);
			compare_field("map_empty", e.map_empty, me);
			compare_field("overflow", e.overflow, ov);
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   stall_cycles;

	mrc_desc_if   desc_ch ();
	mrc_region_if region_ch ();

	region_scoreboard sb = new();

	memory_region_coalescer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.desc   (desc_ch),
		.region (region_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random helpers
	function automatic logic [FRAME_W-1:0] rand_frame();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[FRAME_W-1:0];
	endfunction

	function automatic logic [FRAME_W-1:0] rand_pages();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return rand_frame();
			default: return FRAME_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [TYPE_W-1:0] rand_type();
		if ($urandom_range(0, 4) == 0) begin
			return TYPE_W'($urandom_range(0, 15));
		end
		case ($urandom_range(0, 4))
			0:       return mrc_pkg::MT_LOADER_CODE;
			1:       return mrc_pkg::MT_LOADER_DATA;
			2:       return mrc_pkg::MT_BOOT_CODE;
			3:       return mrc_pkg::MT_BOOT_DATA;
			default: return mrc_pkg::MT_CONVENTIONAL;
		endcase
	endfunction

	function automatic int next_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	// drive one descriptor and hold it until taken
	task automatic send_desc(input logic [TYPE_W-1:0] t, input logic [FRAME_W-1:0] st,
			input logic [FRAME_W-1:0] pg, input logic last, input int gap);
		if (gap > 0) begin
			desc_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		desc_ch.mem_type    <= t;
		desc_ch.start_frame <= st;
		desc_ch.page_count  <= pg;
		desc_ch.last_entry  <= last;
		desc_ch.valid       <= 1'b1;
		do @(posedge clk); while (!desc_ch.ready);
		sb.note_desc(t, st, pg, last);
	endtask

	// sender holds off until every predicted region has been taken
	task automatic wait_drained();
		desc_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	// one map: mostly chains of touching descriptors, sometimes pure noise
	task automatic send_map(input int size, input bit noise, input bit burst);
		logic [FRAME_W-1:0] b_start [$];
		logic [FRAME_W-1:0] b_end [$];
		logic [TYPE_W-1:0]  t;
		logic [FRAME_W-1:0] st, pg;
		int                 sel, j;
		for (int i = 0; i < size; i++) begin
			pg = rand_pages();
			if (noise) begin
				t  = TYPE_W'($urandom_range(0, 15));
				st = rand_frame();
			end else begin
				t   = rand_type();
				sel = $urandom_range(0, 9);
				j   = (b_start.size() > 0) ? $urandom_range(0, b_start.size() - 1) : 0;
				if (b_start.size() > 0 && sel < 4) begin
					st = b_end[j];
				end else if (b_start.size() > 0 && sel < 7) begin
					st = b_start[j] - pg;
				end else if ($urandom_range(0, 3) == 0) begin
					st = rand_frame();
				end else begin
					st = FRAME_W'($urandom_range(0, 4096));
				end
			end
			b_start.push_back(st);
			b_end.push_back(st + pg);
			send_desc(t, st, pg, i == size - 1, next_gap(burst));
		end
	endtask

	// region sink with random stalls and calm stretches
	initial begin : sink_side
		int wait_cycles;
		int calm_left;
		calm_left = 0;
		region_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (calm_left > 0) begin
				calm_left--;
				wait_cycles = 0;
			end else begin
				if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 24);
				wait_cycles = $urandom_range(0, 14);
			end
			if (wait_cycles > 0) begin
				region_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			region_ch.ready <= 1'b1;
			do @(posedge clk); while (!region_ch.valid);
		end
	end

	// check every region item taken
	always @(posedge clk) begin
		if (region_ch.valid && region_ch.ready) begin
			sb.check_region(region_ch.region_start, region_ch.region_pages,
				region_ch.last_region, region_ch.map_empty, region_ch.overflow);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((desc_ch.valid && desc_ch.ready) || (region_ch.valid && region_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// main sequence
	initial begin : source_side
		int items;
		int map_no;
		int size;
		arst_n              <= 1'b0;
		desc_ch.valid       <= 1'b0;
		desc_ch.mem_type    <= '0;
		desc_ch.start_frame <= '0;
		desc_ch.page_count  <= '0;
		desc_ch.last_entry  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// forward, backward across the top of the frame space, unusable, zero length
		send_desc(mrc_pkg::MT_CONVENTIONAL, FRAME_W'(0), FRAME_W'(16), 1'b0, next_gap(0));
		send_desc(mrc_pkg::MT_LOADER_CODE, FRAME_W'(16), FRAME_W'(5), 1'b0, next_gap(0));
		send_desc(mrc_pkg::MT_LOADER_DATA, FRAME_ONES - FRAME_W'(7), FRAME_W'(8), 1'b0,
			next_gap(0));
		send_desc(MT_RUNTIME_CODE, FRAME_W'(21), FRAME_W'(3), 1'b0, next_gap(0));
		send_desc(mrc_pkg::MT_BOOT_CODE, FRAME_W'(21), FRAME_W'(0), 1'b1, next_gap(0));

		// map with nothing usable
		send_desc(MT_RESERVED, FRAME_W'(0), FRAME_W'(1), 1'b1, next_gap(0));

		// all-ones and all-zero fields, page count wrapping to zero
		send_desc(mrc_pkg::MT_BOOT_DATA, FRAME_ONES, FRAME_ONES, 1'b0, next_gap(0));
		send_desc(MT_UNUSABLE, FRAME_W'(0), FRAME_W'(0), 1'b0, next_gap(0));
		send_desc(mrc_pkg::MT_CONVENTIONAL, FRAME_ONES - FRAME_W'(1), FRAME_W'(1), 1'b0,
			next_gap(0));
		send_desc(mrc_pkg::MT_BOOT_CODE, FRAME_W'(0), FRAME_ONES, 1'b1, next_gap(0));

		// every type code once, none touching
		for (int code = 0; code < 16; code++) begin
			send_desc(TYPE_W'(code), FRAME_W'(code * 256), FRAME_W'(1), code == 15, next_gap(1));
		end
		wait_drained();

		// random maps, one of them past capacity
		items  = 0;
		map_no = 0;
		while (items < RANDOM_ITEMS) begin
			size = (map_no == 4) ? MAX_ENTRIES + 3 : $urandom_range(1, 10);
			send_map(size, $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
			items += size;
			if (map_no == 0 || $urandom_range(0, 2) == 0) wait_drained();
			map_no++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.outstanding() != 0) begin
			sb.report($sformatf("%0d expected region items never arrived", sb.outstanding()));
		end
		$display("covered %0d maps from %0d descriptors, %0d region items, %0d joins",
			sb.maps, sb.descs, sb.regions, sb.joins);
		$display("%0d maps dropped descriptors past capacity, %0d left no usable region",
			sb.overflow_maps, sb.empty_maps);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches in total", sb.errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
